// File: design/tcgr_pkg.sv
// ----------------------------------------------------------------------------
// tcgr_pkg
// Shared types, cell geometry and the 5x7 font table of the text renderer.
// ----------------------------------------------------------------------------
package tcgr_pkg;

	localparam int CUR_W = 11;
	localparam int SUM_W = 12;

	localparam logic [3:0] CELL_W    = 4'd6;
	localparam logic [3:0] CELL_H    = 4'd7;
	localparam logic [3:0] LINE_STEP = 4'd8;
	localparam logic [3:0] NO_STEP   = 4'd0;

	localparam logic [7:0] FIRST_CODE = 8'd32;
	localparam logic [7:0] LAST_CODE  = 8'd126;
	localparam logic [7:0] SUBST_CODE = 8'd63;

	localparam int NUM_GLYPHS = 95;
	localparam int GLYPH_COLS = 5;

	typedef logic [CUR_W-1:0] coord_t;

	// six columns of seven row bits, the sixth column is the blank spacing column
	typedef logic [5:0][6:0] glyph_t;

	typedef struct packed {
		coord_t           a;
		logic [3:0]       b;
		logic [SUM_W-1:0] limit;
	} alu_req_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             over;
	} alu_rsp_t;

	localparam logic [7:0] FONT [NUM_GLYPHS][GLYPH_COLS] = '{
		'{8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h00,8'h00,8'h5F,8'h00,8'h00},
		'{8'h00,8'h07,8'h00,8'h07,8'h00}, '{8'h14,8'h7F,8'h14,8'h7F,8'h14},
		'{8'h24,8'h2A,8'h7F,8'h2A,8'h12}, '{8'h23,8'h13,8'h08,8'h64,8'h62},
		'{8'h36,8'h49,8'h55,8'h22,8'h50}, '{8'h00,8'h05,8'h03,8'h00,8'h00},
		'{8'h00,8'h1C,8'h22,8'h41,8'h00}, '{8'h00,8'h41,8'h22,8'h1C,8'h00},
		'{8'h08,8'h2A,8'h1C,8'h2A,8'h08}, '{8'h08,8'h08,8'h3E,8'h08,8'h08},
		'{8'h00,8'h50,8'h30,8'h00,8'h00}, '{8'h08,8'h08,8'h08,8'h08,8'h08},
		'{8'h00,8'h60,8'h60,8'h00,8'h00}, '{8'h20,8'h10,8'h08,8'h04,8'h02},
		'{8'h3E,8'h51,8'h49,8'h45,8'h3E}, '{8'h00,8'h42,8'h7F,8'h40,8'h00},
		'{8'h42,8'h61,8'h51,8'h49,8'h46}, '{8'h21,8'h41,8'h45,8'h4B,8'h31},
		'{8'h18,8'h14,8'h12,8'h7F,8'h10}, '{8'h27,8'h45,8'h45,8'h45,8'h39},
		'{8'h3C,8'h4A,8'h49,8'h49,8'h30}, '{8'h01,8'h71,8'h09,8'h05,8'h03},
		'{8'h36,8'h49,8'h49,8'h49,8'h36}, '{8'h06,8'h49,8'h49,8'h29,8'h1E},
		'{8'h00,8'h36,8'h36,8'h00,8'h00}, '{8'h00,8'h56,8'h36,8'h00,8'h00},
		'{8'h00,8'h08,8'h14,8'h22,8'h41}, '{8'h14,8'h14,8'h14,8'h14,8'h14},
		'{8'h41,8'h22,8'h14,8'h08,8'h00}, '{8'h02,8'h01,8'h51,8'h09,8'h06},
		'{8'h32,8'h49,8'h79,8'h41,8'h3E}, '{8'h7E,8'h11,8'h11,8'h11,8'h7E},
		'{8'h7F,8'h49,8'h49,8'h49,8'h36}, '{8'h3E,8'h41,8'h41,8'h41,8'h22},
		'{8'h7F,8'h41,8'h41,8'h22,8'h1C}, '{8'h7F,8'h49,8'h49,8'h49,8'h41},
		'{8'h7F,8'h09,8'h09,8'h01,8'h01}, '{8'h3E,8'h41,8'h41,8'h51,8'h32},
		'{8'h7F,8'h08,8'h08,8'h08,8'h7F}, '{8'h00,8'h41,8'h7F,8'h41,8'h00},
		'{8'h20,8'h40,8'h41,8'h3F,8'h01}, '{8'h7F,8'h08,8'h14,8'h22,8'h41},
		'{8'h7F,8'h40,8'h40,8'h40,8'h40}, '{8'h7F,8'h02,8'h04,8'h02,8'h7F},
		'{8'h7F,8'h04,8'h08,8'h10,8'h7F}, '{8'h3E,8'h41,8'h41,8'h41,8'h3E},
		'{8'h7F,8'h09,8'h09,8'h09,8'h06}, '{8'h3E,8'h41,8'h51,8'h21,8'h5E},
		'{8'h7F,8'h09,8'h19,8'h29,8'h46}, '{8'h46,8'h49,8'h49,8'h49,8'h31},
		'{8'h01,8'h01,8'h7F,8'h01,8'h01}, '{8'h3F,8'h40,8'h40,8'h40,8'h3F},
		'{8'h1F,8'h20,8'h40,8'h20,8'h1F}, '{8'h7F,8'h20,8'h18,8'h20,8'h7F},
		'{8'h63,8'h14,8'h08,8'h14,8'h63}, '{8'h03,8'h04,8'h78,8'h04,8'h03},
		'{8'h61,8'h51,8'h49,8'h45,8'h43}, '{8'h00,8'h00,8'h7F,8'h41,8'h41},
		'{8'h02,8'h04,8'h08,8'h10,8'h20}, '{8'h41,8'h41,8'h7F,8'h00,8'h00},
		'{8'h04,8'h02,8'h01,8'h02,8'h04}, '{8'h40,8'h40,8'h40,8'h40,8'h40},
		'{8'h00,8'h01,8'h02,8'h04,8'h00}, '{8'h20,8'h54,8'h54,8'h54,8'h78},
		'{8'h7F,8'h48,8'h44,8'h44,8'h38}, '{8'h38,8'h44,8'h44,8'h44,8'h20},
		'{8'h38,8'h44,8'h44,8'h48,8'h7F}, '{8'h38,8'h54,8'h54,8'h54,8'h18},
		'{8'h08,8'h7E,8'h09,8'h01,8'h02}, '{8'h08,8'h14,8'h54,8'h54,8'h3C},
		'{8'h7F,8'h08,8'h04,8'h04,8'h78}, '{8'h00,8'h44,8'h7D,8'h40,8'h00},
		'{8'h20,8'h40,8'h44,8'h3D,8'h00}, '{8'h00,8'h7F,8'h10,8'h28,8'h44},
		'{8'h00,8'h41,8'h7F,8'h40,8'h00}, '{8'h7C,8'h04,8'h18,8'h04,8'h78},
		'{8'h7C,8'h08,8'h04,8'h04,8'h78}, '{8'h38,8'h44,8'h44,8'h44,8'h38},
		'{8'h7C,8'h14,8'h14,8'h14,8'h08}, '{8'h08,8'h14,8'h14,8'h18,8'h7C},
		'{8'h7C,8'h08,8'h04,8'h04,8'h08}, '{8'h48,8'h54,8'h54,8'h54,8'h20},
		'{8'h04,8'h3F,8'h44,8'h40,8'h20}, '{8'h3C,8'h40,8'h40,8'h20,8'h7C},
		'{8'h1C,8'h20,8'h40,8'h20,8'h1C}, '{8'h3C,8'h40,8'h30,8'h40,8'h3C},
		'{8'h44,8'h28,8'h10,8'h28,8'h44}, '{8'h0C,8'h50,8'h50,8'h50,8'h3C},
		'{8'h44,8'h64,8'h54,8'h4C,8'h44}, '{8'h00,8'h08,8'h36,8'h41,8'h00},
		'{8'h00,8'h00,8'h7F,8'h00,8'h00}, '{8'h00,8'h41,8'h36,8'h08,8'h00},
		'{8'h08,8'h08,8'h2A,8'h1C,8'h08}
	};

endpackage

// File: design/tcgr_req_if.sv
// ----------------------------------------------------------------------------
// tcgr_req_if
// Request channel: set-cursor or print-character transactions.
// ----------------------------------------------------------------------------
interface tcgr_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [9:0]  new_x;
	logic [9:0]  new_y;
	logic [7:0]  char_code;
	logic [15:0] fg_color;
	logic [15:0] bg_color;

	modport source (
		output valid, req_type, new_x, new_y, char_code, fg_color, bg_color,
		input  ready
	);
	modport sink (
		input  valid, req_type, new_x, new_y, char_code, fg_color, bg_color,
		output ready
	);
endinterface

// File: design/tcgr_pix_if.sv
// ----------------------------------------------------------------------------
// tcgr_pix_if
// Pixel channel: one transaction per pixel of a character cell.
// ----------------------------------------------------------------------------
interface tcgr_pix_if;
	logic        valid;
	logic        ready;
	logic [9:0]  pixel_x;
	logic [9:0]  pixel_y;
	logic [15:0] pixel_color;
	logic        last_pixel;

	modport source (
		output valid, pixel_x, pixel_y, pixel_color, last_pixel,
		input  ready
	);
	modport sink (
		input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
		output ready
	);
endinterface

// File: design/tcgr_alu.sv
// ----------------------------------------------------------------------------
// tcgr_alu
// Shared add and compare unit for cursor wrap checks and cursor stepping.
// ----------------------------------------------------------------------------
module tcgr_alu import tcgr_pkg::*; (
	input  alu_req_t op,
	output alu_rsp_t res
);

	logic [SUM_W-1:0] sum;

	assign sum      = {1'b0, op.a} + {{(SUM_W-4){1'b0}}, op.b};
	assign res.sum  = sum;
	assign res.over = (sum > op.limit);

endmodule

// File: design/tcgr_glyph_rom.sv
// ----------------------------------------------------------------------------
// tcgr_glyph_rom
// Maps a character byte to its 5x7 glyph, unprintable codes to question mark.
// ----------------------------------------------------------------------------
module tcgr_glyph_rom import tcgr_pkg::*; (
	input  logic [7:0] code,
	output glyph_t     glyph
);

	logic [6:0] idx;

	always_comb begin
		if (code < FIRST_CODE || code > LAST_CODE) begin
			idx = 7'(SUBST_CODE - FIRST_CODE);
		end else begin
			idx = 7'(code - FIRST_CODE);
		end
	end

	always_comb begin
		glyph = '0;
		for (int k = 0; k < GLYPH_COLS; k++) begin
			glyph[k] = FONT[idx][k][6:0];
		end
	end

endmodule

// File: design/text_cursor_glyph_renderer.sv
// ----------------------------------------------------------------------------
// text_cursor_glyph_renderer
// Keeps a text cursor and draws 5x7 characters as 6x7 cells of pixels.
// ----------------------------------------------------------------------------
// channel  modport  transaction
// req      sink     set cursor (req_type 0) or print one character (1)
// pix      source   one pixel: x, y, color, last_pixel on the 42nd
//
// set cursor keeps the block idle, so ready stays high; print runs through
// WRAPX, LINE (only on a line wrap), WRAPY, EMIT and ADV before ready returns.
// the shared adder runs the wrap and line steps before the cell and the
// cursor advance after it; the cell goes out one pixel per cycle unless
// pix stalls, which holds the pixel counters; the last pixel may still
// wait in the output register while the next request is accepted.
// reset puts the cursor at 0,0 and empties the output register.
// ----------------------------------------------------------------------------
module text_cursor_glyph_renderer import tcgr_pkg::*; #(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 240
) (
	input  logic        clk,
	input  logic        arst_n,
	tcgr_req_if.sink    req,
	tcgr_pix_if.source  pix
);

	localparam logic [SUM_W-1:0] W_LIM = SUM_W'(SCREEN_WIDTH);
	localparam logic [SUM_W-1:0] H_LIM = SUM_W'(SCREEN_HEIGHT);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_WRAPX = 3'd1;
	localparam logic [2:0] ST_LINE  = 3'd2;
	localparam logic [2:0] ST_WRAPY = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;
	localparam logic [2:0] ST_ADV   = 3'd5;

	localparam logic [2:0] LAST_COL = 3'(CELL_W - 4'd1);
	localparam logic [2:0] LAST_ROW = 3'(CELL_H - 4'd1);

	logic [2:0]  state_q;
	coord_t      col_q;
	coord_t      row_q;
	logic [2:0]  c_q;
	logic [2:0]  r_q;
	glyph_t      glyph_q;
	logic [15:0] fg_q;
	logic [15:0] bg_q;

	logic        ov_q;
	logic [9:0]  px_q;
	logic [9:0]  py_q;
	logic [15:0] pc_q;
	logic        pl_q;

	glyph_t   rom_glyph;
	alu_req_t alu_op;
	alu_rsp_t alu_res;

	logic req_fire;
	logic load_pix;
	logic cell_end;

	tcgr_glyph_rom u_rom (
		.code  (req.char_code),
		.glyph (rom_glyph)
	);

	tcgr_alu u_alu (
		.op  (alu_op),
		.res (alu_res)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign load_pix  = (state_q == ST_EMIT) && (!ov_q || pix.ready);
	assign cell_end  = (c_q == LAST_COL) && (r_q == LAST_ROW);

	always_comb begin
		alu_op.a     = col_q;
		alu_op.b     = NO_STEP;
		alu_op.limit = W_LIM;
		unique case (state_q)
			ST_WRAPX, ST_ADV: begin
				alu_op.a     = col_q;
				alu_op.b     = CELL_W;
				alu_op.limit = W_LIM;
			end
			ST_LINE: begin
				alu_op.a     = row_q;
				alu_op.b     = LINE_STEP;
				alu_op.limit = H_LIM;
			end
			ST_WRAPY: begin
				alu_op.a     = row_q;
				alu_op.b     = CELL_H;
				alu_op.limit = H_LIM;
			end
			default: begin
				alu_op.a     = col_q;
				alu_op.b     = NO_STEP;
				alu_op.limit = W_LIM;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			c_q     <= '0;
			r_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						if (req.req_type) begin
							state_q <= ST_WRAPX;
						end else begin
							col_q <= {1'b0, req.new_x};
							row_q <= {1'b0, req.new_y};
						end
					end
				end
				ST_WRAPX: begin
					if (alu_res.over) begin
						col_q   <= '0;
						state_q <= ST_LINE;
					end else begin
						state_q <= ST_WRAPY;
					end
				end
				ST_LINE: begin
					row_q   <= alu_res.sum[CUR_W-1:0];
					state_q <= ST_WRAPY;
				end
				ST_WRAPY: begin
					if (alu_res.over) begin
						row_q <= '0;
					end
					c_q     <= '0;
					r_q     <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (load_pix) begin
						if (c_q == LAST_COL) begin
							c_q <= '0;
							r_q <= r_q + 3'd1;
						end else begin
							c_q <= c_q + 3'd1;
						end
						if (cell_end) begin
							state_q <= ST_ADV;
						end
					end
				end
				ST_ADV: begin
					col_q   <= alu_res.sum[CUR_W-1:0];
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// character payload latched with the print transaction
	always_ff @(posedge clk) begin
		if (req_fire && req.req_type) begin
			glyph_q <= rom_glyph;
			fg_q    <= req.fg_color;
			bg_q    <= req.bg_color;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (load_pix) begin
			ov_q <= 1'b1;
		end else if (pix.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_pix) begin
			px_q <= col_q[9:0] + {7'd0, c_q};
			py_q <= row_q[9:0] + {7'd0, r_q};
			pc_q <= glyph_q[c_q][r_q] ? fg_q : bg_q;
			pl_q <= cell_end;
		end
	end

	assign pix.valid       = ov_q;
	assign pix.pixel_x     = px_q;
	assign pix.pixel_y     = py_q;
	assign pix.pixel_color = pc_q;
	assign pix.last_pixel  = pl_q;

endmodule

// File: design/tcgr_checker.sv
// ----------------------------------------------------------------------------
// tcgr_checker
// Port-level checks of the text renderer, bound to the top level.
// ----------------------------------------------------------------------------
module tcgr_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_req_type,
	input logic out_valid,
	input logic out_ready,
	input logic out_last
);

	logic in_fire;

	assign in_fire = in_valid && in_ready;

	// a pixel stays offered until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("pixel dropped before its transaction");

	// no request is taken while a cell is still being sent
	a_busy_cell: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> !in_ready)
		else $error("request ready in the middle of a cell");

	// a print transaction occupies the block
	a_print_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_req_type |=> !in_ready)
		else $error("ready right after a print transaction");

	// a set-cursor transaction leaves the block ready
	a_set_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !in_req_type |=> in_ready)
		else $error("not ready after a set-cursor transaction");

endmodule

bind text_cursor_glyph_renderer tcgr_checker u_tcgr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (req.valid),
	.in_ready    (req.ready),
	.in_req_type (req.req_type),
	.out_valid   (pix.valid),
	.out_ready   (pix.ready),
	.out_last    (pix.last_pixel)
);
